/* rtl/mpt_pkg.sv */
// ----------------------------------------------------------------------------
// mpt_pkg
// Types, constants and helpers shared by the motion period tracker files.
// ----------------------------------------------------------------------------
package mpt_pkg;

  localparam int unsigned AxisCountDefault = 3;
  localparam int unsigned TickBitsDefault  = 32;
  localparam int unsigned AddrW            = 5;
  localparam int unsigned DataW            = 32;

  // divider operand widths for the position mapping
  localparam int unsigned DivNumW = 29;
  localparam int unsigned DivDenW = 13;
  localparam int unsigned DivQW   = 16;

  localparam logic [8:0]  AlphaFull    = 9'd256;
  localparam logic [15:0] PosCenter    = 16'h8000;
  localparam logic [8:0]  FiltAlphaRst = 9'd64;
  localparam logic [8:0]  PerAlphaRst  = 9'd64;
  localparam logic [10:0] ActThrRst    = 11'd200;
  localparam logic [15:0] MaxPerRst    = 16'd200;
  localparam logic [7:0]  DebounceRst  = 8'd3;
  localparam logic [15:0] Limit1Rst    = 16'd20;
  localparam logic [15:0] Limit2Rst    = 16'd50;
  localparam logic [15:0] Limit3Rst    = 16'd100;

  typedef enum logic [2:0] {
    REG_FILTER_ALPHA = 3'd0,
    REG_PERIOD_ALPHA = 3'd1,
    REG_ACT_THR      = 3'd2,
    REG_MAX_PERIOD   = 3'd3,
    REG_DEBOUNCE     = 3'd4,
    REG_LIMIT_ONE    = 3'd5,
    REG_LIMIT_TWO    = 3'd6,
    REG_LIMIT_THREE  = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT,
    ST_TRACK,
    ST_SMOOTH,
    ST_POS,
    ST_DIV,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    SP_KEEP,
    SP_DECAY,
    SP_SMOOTH
  } sp_op_e;

  typedef struct packed {
    logic [8:0]  filter_alpha;
    logic [8:0]  per_alpha;
    logic [10:0] activity_threshold;
    logic [15:0] period_limit;
    logic [7:0]  debounce_len;
    logic [15:0] mode_limit_one;
    logic [15:0] mode_limit_two;
    logic [15:0] mode_limit_three;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivQW-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic        new_data;
    logic [11:0] raw_x;
    logic [11:0] raw_y;
    logic [11:0] raw_z;
  } in_item_t;

  typedef struct packed {
    logic signed [11:0] filt_x;
    logic signed [11:0] filt_y;
    logic signed [11:0] filt_z;
    logic [15:0]        period_x;
    logic [15:0]        period_y;
    logic [15:0]        period_z;
    logic [1:0]         mode_x;
    logic [1:0]         mode_y;
    logic [1:0]         mode_z;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic [15:0]        pos_z;
  } out_item_t;

  function automatic logic [8:0] sat_alpha(input logic [8:0] a);
    sat_alpha = (a > AlphaFull) ? AlphaFull : a;
  endfunction

endpackage

/* rtl/motion_period_tracker_unit.sv */
// ----------------------------------------------------------------------------
// motion_period_tracker_unit
// Per-axis low-pass filter, peak period tracker, mode classifier and
// position mapper, run axis by axis under a small sequencer.
// ----------------------------------------------------------------------------
// sequence: accept in ST_IDLE, filter every axis in ST_FILT, then per axis ST_TRACK,
//   ST_SMOOTH, ST_POS and ST_DIV (ST_DIV skipped when the local maximum is not positive)
// a new item is taken only in ST_IDLE, once the previous item is in the output register;
//   the 16-step shared divider serves all axes; a stalled result holds the block
// items with new_data clear are taken while idle and give no result
// reset: all tracker state cleared, debounce loaded with 3, registers to defaults
module motion_period_tracker_unit #(
  parameter int unsigned AXIS_COUNT = mpt_pkg::AxisCountDefault,
  parameter int unsigned TICK_BITS  = mpt_pkg::TickBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  mpt_pkg::in_item_t         in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output mpt_pkg::out_item_t        out_item_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mpt_pkg::AddrW-1:0] paddr,
  input  logic [mpt_pkg::DataW-1:0] pwdata,
  output logic [mpt_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  localparam int unsigned AxW  = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
  localparam int unsigned TW   = TICK_BITS;

  mpt_pkg::cfg_t     cfg;
  mpt_pkg::div_req_t div_req;
  mpt_pkg::div_rsp_t div_rsp;
  mpt_pkg::state_e   state_q, state_d;
  mpt_pkg::sp_op_e   sp_op_q, sp_op_d;

  mpt_cfg_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  mpt_divider u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // per-axis tracker state
  logic signed [11:0] filt_q [AXIS_COUNT];
  logic signed [12:0] max_q  [AXIS_COUNT];
  logic [7:0]         deb_q  [AXIS_COUNT];
  logic [TW-1:0]      pt_q   [AXIS_COUNT];
  logic [15:0]        sp_q   [AXIS_COUNT];
  logic [1:0]         mode_q [AXIS_COUNT];
  logic [15:0]        pos_q  [AXIS_COUNT];

  logic [TW-1:0]      tick_q;
  logic [AxW-1:0]     idx_q, idx_d;
  mpt_pkg::in_item_t  in_q;
  logic [15:0]        fresh_q, fresh_d;
  logic               out_valid_q, out_valid_d;
  mpt_pkg::out_item_t out_q, out_d;

  logic [8:0]         a9, p9, pc9, ac9;
  logic [11:0]        raw_sel;
  logic signed [20:0] raw_e, filt_e, a_e, b_e, num;
  logic signed [20:0] num_sh;
  logic signed [11:0] filt_new;

  logic signed [11:0] lp;
  logic signed [12:0] lp13, m0, m1, m2, neg_lp, v;
  logic signed [15:0] four_lp, m16, three_m;
  logic               active, timeout;
  logic [7:0]         deb1;
  logic [TW-1:0]      pt1, fresh, since;
  logic [TW-1:0]      maxp_e;

  logic [15:0]        sp0, sp_new;
  logic [24:0]        decay_prod, smooth_sum;
  logic [1:0]         mode_new;

  logic signed [13:0] vm;
  logic [12:0]        vm_u;
  logic               last_axis;

  assign a9        = mpt_pkg::sat_alpha(cfg.filter_alpha);
  assign p9        = mpt_pkg::sat_alpha(cfg.per_alpha);
  assign ac9       = 9'(mpt_pkg::AlphaFull - a9);
  assign pc9       = 9'(mpt_pkg::AlphaFull - p9);
  assign maxp_e    = TW'(cfg.period_limit);
  assign last_axis = (idx_q == AxW'(AXIS_COUNT - 1));

  always_comb begin
    unique case (idx_q)
      AxW'(0):  raw_sel = in_q.raw_x;
      AxW'(1):  raw_sel = in_q.raw_y;
      default:  raw_sel = in_q.raw_z;
    endcase
  end

  // low-pass filter, division by 256 truncating toward zero
  always_comb begin
    raw_e    = 21'($signed(raw_sel));
    filt_e   = 21'(filt_q[idx_q]);
    a_e      = 21'($signed({1'b0, a9}));
    b_e      = 21'($signed({1'b0, ac9}));
    num      = a_e * raw_e + b_e * filt_e;
    num_sh   = num >>> 8;
    if (num[20] && (num[7:0] != 8'd0)) begin
      num_sh = num_sh + 21'sd1;
    end
    filt_new = num_sh[11:0];
  end

  // raise maximum, peak detection and timeout
  always_comb begin
    lp      = filt_q[idx_q];
    lp13    = 13'(lp);
    m0      = max_q[idx_q];
    m1      = m0;
    if (lp13 > m0) begin
      m1 = lp13[12] ? -lp13 : lp13;
    end
    active  = m1 > $signed({2'b00, cfg.activity_threshold});
    four_lp = 16'(lp) <<< 2;
    m16     = 16'(m1);
    three_m = m16 + (m16 <<< 1);
    deb1    = deb_q[idx_q];
    pt1     = pt_q[idx_q];
    fresh   = '0;
    if (four_lp > three_m && deb_q[idx_q] == 8'd0) begin
      deb1 = cfg.debounce_len;
      if (pt_q[idx_q] == '0) begin
        pt1 = tick_q;
      end else begin
        if (tick_q > pt_q[idx_q]) begin
          fresh = tick_q - pt_q[idx_q];
        end
        pt1 = '0;
      end
    end else if (four_lp < three_m && deb_q[idx_q] != 8'd0) begin
      deb1 = deb_q[idx_q] - 8'd1;
    end
    since   = tick_q - pt1;
    timeout = (pt1 != '0) && (tick_q > pt1) && (since > maxp_e);
    m2      = m1;
    sp_op_d = mpt_pkg::SP_KEEP;
    fresh_d = fresh[15:0];
    if (!active) begin
      sp_op_d = mpt_pkg::SP_DECAY;
      deb1    = deb_q[idx_q];
      pt1     = pt_q[idx_q];
    end else if (timeout) begin
      sp_op_d = mpt_pkg::SP_DECAY;
      m2      = '0;
      deb1    = cfg.debounce_len;
      pt1     = '0;
    end else if (fresh != '0 && fresh < maxp_e) begin
      sp_op_d = mpt_pkg::SP_SMOOTH;
    end
  end

  // period update and mode
  always_comb begin
    sp0        = sp_q[idx_q];
    decay_prod = 25'(sp0) * 25'(pc9);
    smooth_sum = 25'(p9) * 25'(fresh_q) + 25'(pc9) * 25'(sp0);
    unique case (sp_op_q)
      mpt_pkg::SP_DECAY:  sp_new = decay_prod[23:8];
      mpt_pkg::SP_SMOOTH: sp_new = smooth_sum[23:8];
      default:            sp_new = sp0;
    endcase
    if (sp_new < cfg.mode_limit_one) begin
      mode_new = 2'd0;
    end else if (sp_new < cfg.mode_limit_two) begin
      mode_new = 2'd1;
    end else if (sp_new < cfg.mode_limit_three) begin
      mode_new = 2'd2;
    end else begin
      mode_new = 2'd3;
    end
  end

  // position operands: (v + m) * 65535 over 2m
  always_comb begin
    neg_lp = -lp13;
    v      = neg_lp;
    if (v < -m0) begin
      v = -m0;
    end
    if (v > m0) begin
      v = m0;
    end
    vm           = 14'(v) + 14'(m0);
    vm_u         = vm[12:0];
    div_req.num  = ({vm_u, 16'd0}) - 29'(vm_u);
    div_req.den  = {m0[11:0], 1'b0};
    div_req.start = (state_q == mpt_pkg::ST_POS) && (m0 > 13'sd0);
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    in_ready_o  = (state_q == mpt_pkg::ST_IDLE);
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      mpt_pkg::ST_IDLE: begin
        idx_d = '0;
        if (in_valid_i && in_item_i.new_data) begin
          state_d = mpt_pkg::ST_FILT;
        end
      end
      mpt_pkg::ST_FILT: begin
        if (last_axis) begin
          idx_d   = '0;
          state_d = mpt_pkg::ST_TRACK;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      mpt_pkg::ST_TRACK:  state_d = mpt_pkg::ST_SMOOTH;
      mpt_pkg::ST_SMOOTH: state_d = mpt_pkg::ST_POS;
      mpt_pkg::ST_POS: begin
        if (m0 > 13'sd0) begin
          state_d = mpt_pkg::ST_DIV;
        end else if (last_axis) begin
          state_d = mpt_pkg::ST_FINISH;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = mpt_pkg::ST_TRACK;
        end
      end
      mpt_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          if (last_axis) begin
            state_d = mpt_pkg::ST_FINISH;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = mpt_pkg::ST_TRACK;
          end
        end
      end
      mpt_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.filt_x   = filt_q[0];
          out_d.period_x = sp_q[0];
          out_d.mode_x   = mode_q[0];
          out_d.pos_x    = pos_q[0];
          if (AXIS_COUNT > 1) begin
            out_d.filt_y   = filt_q[AxW'(1)];
            out_d.period_y = sp_q[AxW'(1)];
            out_d.mode_y   = mode_q[AxW'(1)];
            out_d.pos_y    = pos_q[AxW'(1)];
          end
          if (AXIS_COUNT > 2) begin
            out_d.filt_z   = filt_q[AxW'(2)];
            out_d.period_z = sp_q[AxW'(2)];
            out_d.mode_z   = mode_q[AxW'(2)];
            out_d.pos_z    = pos_q[AxW'(2)];
          end
          state_d = mpt_pkg::ST_IDLE;
        end
      end
      default: state_d = mpt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mpt_pkg::ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      tick_q      <= '0;
      for (int k = 0; k < AXIS_COUNT; k++) begin
        filt_q[k] <= '0;
        max_q[k]  <= '0;
        deb_q[k]  <= mpt_pkg::DebounceRst;
        pt_q[k]   <= '0;
        sp_q[k]   <= '0;
        mode_q[k] <= '0;
        pos_q[k]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      unique case (state_q)
        mpt_pkg::ST_FILT: filt_q[idx_q] <= filt_new;
        mpt_pkg::ST_TRACK: begin
          max_q[idx_q] <= m2 - 13'sd1;
          deb_q[idx_q] <= deb1;
          pt_q[idx_q]  <= pt1;
        end
        mpt_pkg::ST_SMOOTH: begin
          sp_q[idx_q]   <= sp_new;
          mode_q[idx_q] <= mode_new;
        end
        mpt_pkg::ST_POS: begin
          if (!(m0 > 13'sd0)) begin
            pos_q[idx_q] <= mpt_pkg::PosCenter;
          end
        end
        mpt_pkg::ST_DIV: begin
          if (div_rsp.done) begin
            pos_q[idx_q] <= div_rsp.quot;
          end
        end
        mpt_pkg::ST_FINISH: begin
          if (!out_valid_q || out_ready_i) begin
            tick_q <= tick_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
    if (state_q == mpt_pkg::ST_TRACK) begin
      sp_op_q <= sp_op_d;
      fresh_q <= fresh_d;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* rtl/mpt_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mpt_cfg_regs
// APB register file holding the tracker configuration.
// ----------------------------------------------------------------------------
module mpt_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mpt_pkg::AddrW-1:0]  paddr,
  input  logic [mpt_pkg::DataW-1:0]  pwdata,
  output logic [mpt_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output mpt_pkg::cfg_t              cfg_o
);

  mpt_pkg::cfg_t    cfg_q, cfg_d;
  mpt_pkg::reg_idx_e sel;
  logic             wr_en;

  assign pready = 1'b1;
  assign sel    = mpt_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        mpt_pkg::REG_FILTER_ALPHA: cfg_d.filter_alpha       = pwdata[8:0];
        mpt_pkg::REG_PERIOD_ALPHA: cfg_d.per_alpha          = pwdata[8:0];
        mpt_pkg::REG_ACT_THR:      cfg_d.activity_threshold = pwdata[10:0];
        mpt_pkg::REG_MAX_PERIOD:   cfg_d.period_limit       = pwdata[15:0];
        mpt_pkg::REG_DEBOUNCE:     cfg_d.debounce_len       = pwdata[7:0];
        mpt_pkg::REG_LIMIT_ONE:    cfg_d.mode_limit_one     = pwdata[15:0];
        mpt_pkg::REG_LIMIT_TWO:    cfg_d.mode_limit_two     = pwdata[15:0];
        mpt_pkg::REG_LIMIT_THREE:  cfg_d.mode_limit_three   = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (sel)
      mpt_pkg::REG_FILTER_ALPHA: prdata = 32'(cfg_q.filter_alpha);
      mpt_pkg::REG_PERIOD_ALPHA: prdata = 32'(cfg_q.per_alpha);
      mpt_pkg::REG_ACT_THR:      prdata = 32'(cfg_q.activity_threshold);
      mpt_pkg::REG_MAX_PERIOD:   prdata = 32'(cfg_q.period_limit);
      mpt_pkg::REG_DEBOUNCE:     prdata = 32'(cfg_q.debounce_len);
      mpt_pkg::REG_LIMIT_ONE:    prdata = 32'(cfg_q.mode_limit_one);
      mpt_pkg::REG_LIMIT_TWO:    prdata = 32'(cfg_q.mode_limit_two);
      mpt_pkg::REG_LIMIT_THREE:  prdata = 32'(cfg_q.mode_limit_three);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_alpha       <= mpt_pkg::FiltAlphaRst;
      cfg_q.per_alpha          <= mpt_pkg::PerAlphaRst;
      cfg_q.activity_threshold <= mpt_pkg::ActThrRst;
      cfg_q.period_limit       <= mpt_pkg::MaxPerRst;
      cfg_q.debounce_len       <= mpt_pkg::DebounceRst;
      cfg_q.mode_limit_one     <= mpt_pkg::Limit1Rst;
      cfg_q.mode_limit_two     <= mpt_pkg::Limit2Rst;
      cfg_q.mode_limit_three   <= mpt_pkg::Limit3Rst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* rtl/mpt_divider.sv */
// ----------------------------------------------------------------------------
// mpt_divider
// Restoring divider, one quotient bit per cycle, for the position mapping.
// ----------------------------------------------------------------------------
module mpt_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mpt_pkg::div_req_t req_i,
  output mpt_pkg::div_rsp_t rsp_o
);

  localparam int unsigned QW   = mpt_pkg::DivQW;
  localparam int unsigned DW   = mpt_pkg::DivDenW;
  localparam int unsigned NW   = mpt_pkg::DivNumW;
  localparam int unsigned CntW = $clog2(QW + 1);

  logic [DW-1:0]   rem_q, rem_d;
  logic [QW-1:0]   low_q, low_d;
  logic [QW-1:0]   quot_q, quot_d;
  logic [DW-1:0]   den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DW:0]     trial;
  logic [DW:0]     diff;

  assign trial = {rem_q, low_q[QW-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    low_d  = low_q;
    quot_d = quot_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      // quotient is known to fit, so the top part starts below the divisor
      rem_d  = req_i.num[NW-1:QW];
      low_d  = req_i.num[QW-1:0];
      den_d  = req_i.den;
      cnt_d  = CntW'(QW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = diff[DW-1:0];
        quot_d = {quot_q[QW-2:0], 1'b1};
      end else begin
        rem_d  = trial[DW-1:0];
        quot_d = {quot_q[QW-2:0], 1'b0};
      end
      low_d = {low_q[QW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    low_q  <= low_d;
    quot_q <= quot_d;
    den_q  <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule
